[rtl/avr_pkg.sv]
// Package: shared constants, codes, quarter-wave sine table and arithmetic helpers.
`timescale 1ns / 1ps

package avr_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int TRIG_W  = 16;
    localparam int ANGLE_W = 11;
    localparam int AXIS_W  = 2;
    localparam int OP_W    = 1;
    localparam int PROD_W  = COORD_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_W = SUM_W - FRAC_SHIFT;

    // Angle storage: one entry
    localparam int ANGLE_DEPTH = 1;

    // Angle constants in quarter degrees
    localparam logic [ANGLE_W-1:0] FULL_TURN    = 11'd1440;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 11'd720;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 11'd360;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 11'd1080;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 1'b0;
    localparam logic [OP_W-1:0] OP_VERTEX = 1'b1;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_PASS = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;
    localparam logic [AXIS_W-1:0] AXIS_RESET = AXIS_X;

    // Quarter-wave table, Q1.14 magnitudes 0..16384
    localparam int TABLE_LEN = 361;
    localparam int TABLE_IDX_W = 9;
    localparam int TABLE_W = 15;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [TABLE_W-1:0] qtable_t [0:TABLE_LEN-1];

    // Unsigned quotient by shift and subtract, used only for the table build
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        int i;
        q = 64'd0;
        rem = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30, evaluated at elaboration only
    function automatic qtable_t build_qtable();
        qtable_t t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint acc;
        longint r;
        int unsigned n;
        int unsigned k;
        for (k = 0; k < TABLE_LEN; k++)
        begin
            x = udiv(longint'(k) * PI_Q30 + 64'd360, 64'd720);
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (n = 1; n <= 7; n++)
            begin
                term = udiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
                if (n[0])
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            r = (acc + 32768) >>> 16;
            if (r > 16384)
            begin
                r = 16384;
            end
            t[k] = TABLE_W'(r);
        end
        return t;
    endfunction

    localparam qtable_t QTABLE = build_qtable();

    // Sine of a quarter-degree angle below two full turns, mirrored from the table
    function automatic logic signed [TRIG_W-1:0] trig_lookup(input logic [ANGLE_W-1:0] q);
        logic [ANGLE_W-1:0] qm;
        logic [ANGLE_W-1:0] fold;
        logic neg;
        logic signed [TRIG_W-1:0] mag;
        qm = (q >= FULL_TURN) ? (q - FULL_TURN) : q;
        if (qm <= QUARTER_TURN)
        begin
            fold = qm;
            neg = 1'b0;
        end
        else if (qm <= HALF_TURN)
        begin
            fold = HALF_TURN - qm;
            neg = 1'b0;
        end
        else if (qm <= THREE_QUARTER_TURN)
        begin
            fold = qm - HALF_TURN;
            neg = 1'b1;
        end
        else
        begin
            fold = FULL_TURN - qm;
            neg = 1'b1;
        end
        mag = signed'({1'b0, QTABLE[fold[TABLE_IDX_W-1:0]]});
        return neg ? -mag : mag;
    endfunction

    // Q4.26 sum to Q3.12: round half up, then saturate
    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        logic signed [ROUND_W-1:0] r;
        logic signed [COORD_W-1:0] res;
        t = s + SUM_W'(signed'(34'sd8192));
        r = t[SUM_W-1:FRAC_SHIFT];
        if (r > ROUND_W'(signed'(20'sd32767)))
        begin
            res = 16'sh7FFF;
        end
        else if (r < ROUND_W'(signed'(-20'sd32768)))
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = r[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/avr_vertex_if.sv]
// Interface: input request channel carrying operation and vertex coordinates.
`timescale 1ns / 1ps

interface avr_vertex_if;
    logic                                  valid;
    logic                                  ready;
    logic [avr_pkg::OP_W-1:0]              operation;
    logic signed [avr_pkg::COORD_W-1:0]    vertex_x;
    logic signed [avr_pkg::COORD_W-1:0]    vertex_y;
    logic signed [avr_pkg::COORD_W-1:0]    vertex_z;

    modport source (output valid, operation, vertex_x, vertex_y, vertex_z, input ready);
    modport sink   (input valid, operation, vertex_x, vertex_y, vertex_z, output ready);
endinterface

[rtl/avr_result_if.sv]
// Interface: output request channel carrying the rotated vertex.
`timescale 1ns / 1ps

interface avr_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [avr_pkg::COORD_W-1:0]    rotated_x;
    logic signed [avr_pkg::COORD_W-1:0]    rotated_y;
    logic signed [avr_pkg::COORD_W-1:0]    rotated_z;

    modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

[rtl/avr_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module avr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/avr_angle_ctrl.sv]
// Angle store: read-modify-write of the quarter-degree angle with write forwarding.
`timescale 1ns / 1ps

module avr_angle_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    output logic [avr_pkg::ANGLE_W-1:0] angle
);

    localparam int AW = (avr_pkg::ANGLE_DEPTH > 1) ? $clog2(avr_pkg::ANGLE_DEPTH) : 1;

    logic [avr_pkg::ANGLE_W-1:0] rd_data;
    logic [avr_pkg::ANGLE_W-1:0] angle_inc;
    logic                        fwd_valid_reg;
    logic                        fwd_valid_next;
    logic [avr_pkg::ANGLE_W-1:0] fwd_data_reg;
    logic [avr_pkg::ANGLE_W-1:0] fwd_data_next;
    logic                        written_reg;
    logic                        written_next;

    avr_ram #(
        .WIDTH (avr_pkg::ANGLE_W),
        .DEPTH (avr_pkg::ANGLE_DEPTH)
    ) u_angle_ram (
        .clk   (clk),
        .we    (tick),
        .waddr (AW'(0)),
        .wdata (angle_inc),
        .raddr (AW'(0)),
        .rdata (rd_data)
    );

    // Current angle: last write if it has not reached the read data yet,
    // reset value until the entry is first written
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            angle = fwd_data_reg;
        end
        else if (written_reg)
        begin
            angle = rd_data;
        end
        else
        begin
            angle = '0;
        end
    end

    // Advance with wrap at a full turn
    assign angle_inc = (angle >= avr_pkg::FULL_TURN) ? '0 : (angle + 1'b1);

    // Forwarding and written flag
    always_comb
    begin
        fwd_valid_next = tick;
        fwd_data_next  = tick ? angle_inc : fwd_data_reg;
        written_next   = written_reg | tick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            fwd_data_reg  <= '0;
            written_reg   <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
            fwd_data_reg  <= fwd_data_next;
            written_reg   <= written_next;
        end
    end

    // Checks
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle <= avr_pkg::FULL_TURN)
        else $error("angle beyond a full turn");

    a_tick_update: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> angle == $past(angle_inc))
        else $error("angle not advanced after tick");

endmodule

[rtl/avr_rotate_pipe.sv]
// Rotation pipeline: trig lookup, products, round and saturate into the output register.
`timescale 1ns / 1ps

module avr_rotate_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [avr_pkg::AXIS_W-1:0]  axis,
    input  logic [avr_pkg::ANGLE_W-1:0] angle,
    output logic                        tick,
    avr_vertex_if.sink                  vin,
    avr_result_if.source                vout
);

    typedef logic signed [avr_pkg::COORD_W-1:0] coord_t;
    typedef logic signed [avr_pkg::TRIG_W-1:0]  trig_t;
    typedef logic signed [avr_pkg::PROD_W-1:0]  prod_t;
    typedef logic signed [avr_pkg::SUM_W-1:0]   sum_t;

    logic adv1;
    logic adv2;
    logic adv3;
    logic vertex_fire;

    // Stage 1: vertex and trig values
    logic                       v1_reg, v1_next;
    coord_t                     x1_reg, y1_reg, z1_reg;
    logic [avr_pkg::AXIS_W-1:0] axis1_reg;
    trig_t                      sin1_reg, cos1_reg;

    // Stage 2: products
    logic                       v2_reg, v2_next;
    coord_t                     x2_reg, y2_reg, z2_reg;
    logic [avr_pkg::AXIS_W-1:0] axis2_reg;
    prod_t                      ac_reg, bs_reg, as_reg, bc_reg;
    coord_t                     opa, opb;
    prod_t                      ac_next, bs_next, as_next, bc_next;

    // Stage 3: output register
    logic                       ov_reg, ov_next;
    coord_t                     rx_reg, ry_reg, rz_reg;
    coord_t                     rx_next, ry_next, rz_next;
    sum_t                       diff_sum, plus_sum;
    coord_t                     diff_r, plus_r;

    // Stall chain
    assign adv3 = !ov_reg || vout.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign vin.ready = adv1;

    assign vertex_fire = vin.valid && adv1 && (vin.operation == avr_pkg::OP_VERTEX);
    assign tick        = vin.valid && adv1 && (vin.operation == avr_pkg::OP_TICK);

    // Valid bits
    always_comb
    begin
        v1_next = adv1 ? vertex_fire : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
        ov_next = adv3 ? v2_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    // Stage 1 load: sine and cosine at the angle seen on acceptance
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg    <= vin.vertex_x;
            y1_reg    <= vin.vertex_y;
            z1_reg    <= vin.vertex_z;
            axis1_reg <= axis;
            sin1_reg  <= avr_pkg::trig_lookup(angle);
            cos1_reg  <= avr_pkg::trig_lookup(angle + avr_pkg::QUARTER_TURN);
        end
    end

    // Operand pairing: first = a*c - b*s, second = a*s + b*c
    always_comb
    begin
        case (axis1_reg)
            avr_pkg::AXIS_X:
            begin
                opa = y1_reg;
                opb = z1_reg;
            end
            avr_pkg::AXIS_Y:
            begin
                opa = z1_reg;
                opb = x1_reg;
            end
            default:
            begin
                opa = x1_reg;
                opb = y1_reg;
            end
        endcase
        ac_next = opa * cos1_reg;
        bs_next = opb * sin1_reg;
        as_next = opa * sin1_reg;
        bc_next = opb * cos1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            axis2_reg <= axis1_reg;
            ac_reg    <= ac_next;
            bs_reg    <= bs_next;
            as_reg    <= as_next;
            bc_reg    <= bc_next;
        end
    end

    // Sums, rounding and placement by axis
    always_comb
    begin
        diff_sum = avr_pkg::SUM_W'(ac_reg) - avr_pkg::SUM_W'(bs_reg);
        plus_sum = avr_pkg::SUM_W'(as_reg) + avr_pkg::SUM_W'(bc_reg);
        diff_r   = avr_pkg::round_sat(diff_sum);
        plus_r   = avr_pkg::round_sat(plus_sum);
        rx_next  = x2_reg;
        ry_next  = y2_reg;
        rz_next  = z2_reg;
        case (axis2_reg)
            avr_pkg::AXIS_X:
            begin
                ry_next = diff_r;
                rz_next = plus_r;
            end
            avr_pkg::AXIS_Y:
            begin
                rx_next = plus_r;
                rz_next = diff_r;
            end
            avr_pkg::AXIS_Z:
            begin
                rx_next = diff_r;
                ry_next = plus_r;
            end
            default:
            begin
                rx_next = x2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
    end

    assign vout.valid     = ov_reg;
    assign vout.rotated_x = rx_reg;
    assign vout.rotated_y = ry_reg;
    assign vout.rotated_z = rz_reg;

    // Checks
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(v2_reg))
        else $error("result appeared without a product stage request");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv2) |=> (v1_reg && $stable(axis1_reg) && $stable(sin1_reg)))
        else $error("stalled trig stage lost its request");

    a_tick_no_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> !v1_reg)
        else $error("tick entered the rotation pipeline");

endmodule

[rtl/axis_vertex_rotator_core.sv]
// Top level: vertex rotator about a configured principal axis with a running angle.
//
//  channel    | dir | handshake     | payload
//  -----------+-----+---------------+-------------------------------------------
//  vertices   | in  | valid / ready | operation, vertex_x, vertex_y, vertex_z
//  results    | out | valid / ready | rotated_x, rotated_y, rotated_z
//  cfg        | in  | cfg_we        | cfg_wdata = rotation_axis
//
//  One request per cycle unless results stall; vertices pass trig, product, output stages.
//  A tick updates the angle RAM entry at acceptance; forwarding of the last write lets a
//  request in the very next cycle see the new angle.
//  Reset clears the pipeline valids and reads the angle as zero until first written.
//  A stalled output holds the pipeline stage by stage; empty stages still take requests.
`timescale 1ns / 1ps

module axis_vertex_rotator_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [avr_pkg::AXIS_W-1:0] cfg_wdata,
    avr_vertex_if.sink                 vertices,
    avr_result_if.source               results
);

    logic [avr_pkg::AXIS_W-1:0]  axis_reg;
    logic [avr_pkg::AXIS_W-1:0]  axis_next;
    logic [avr_pkg::ANGLE_W-1:0] angle;
    logic                        tick;

    // Configuration register
    assign axis_next = cfg_we ? cfg_wdata : axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= avr_pkg::AXIS_RESET;
        end
        else
        begin
            axis_reg <= axis_next;
        end
    end

    avr_angle_ctrl u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .angle (angle)
    );

    avr_rotate_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .axis  (axis_reg),
        .angle (angle),
        .tick  (tick),
        .vin   (vertices),
        .vout  (results)
    );

endmodule

[tb/sv/tb_avr_checker.sv]
// Checker: tracks angle and axis, predicts each rotated vertex and compares with the output.
`timescale 1ns / 1ps

module tb_avr_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [avr_pkg::AXIS_W-1:0] cfg_wdata,
    avr_vertex_if                      vin,
    avr_result_if                      vout,
    output int                         fail_count,
    output int                         pending
);
    import avr_pkg::*;

    // pi in Q30 radians
    localparam longint unsigned PI_RAD_Q30 = 64'd3373259426;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } rotated_vertex_t;

    int              sine_mag [0:360];
    logic [ANGLE_W-1:0] angle_qd;
    logic [AXIS_W-1:0]  axis_sel;
    rotated_vertex_t rotated_q [$];
    rotated_vertex_t want;
    int              errors;

    // Q1.14 sine of k quarter degrees, 0..90 degrees, Taylor series in Q30
    function automatic int quarter_wave_q14(int unsigned k);
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned term;
        longint acc;
        longint r;
        int unsigned n;
        rad = (64'(k) * PI_RAD_Q30 + 64'd360) / 64'd720;
        rad_sq = (rad * rad) >> 30;
        term = rad;
        acc = longint'(rad);
        for (n = 1; n <= 7; n++)
        begin
            term = ((term * rad_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (acc + 32768) >>> 16;
        if (r > 16384)
        begin
            r = 16384;
        end
        return int'(r);
    endfunction

    // full-turn sine from the quarter wave by mirroring
    function automatic int sine_q14(int unsigned q);
        int unsigned qm;
        qm = q % int'(FULL_TURN);
        if (qm <= QUARTER_TURN)
        begin
            return sine_mag[qm];
        end
        if (qm <= HALF_TURN)
        begin
            return sine_mag[HALF_TURN - qm];
        end
        if (qm <= THREE_QUARTER_TURN)
        begin
            return -sine_mag[qm - HALF_TURN];
        end
        return -sine_mag[FULL_TURN - qm];
    endfunction

    // Q4.26 to Q3.12, round half up, saturate
    function automatic logic signed [COORD_W-1:0] sat_q12(longint s);
        longint r;
        r = (s + 64'sd8192) >>> 14;
        if (r > 32767)
        begin
            r = 32767;
        end
        else if (r < -32768)
        begin
            r = -32768;
        end
        return r[COORD_W-1:0];
    endfunction

    function automatic rotated_vertex_t rotate_vertex(
        input logic [AXIS_W-1:0]       ax,
        input logic [ANGLE_W-1:0]      ang,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z
    );
        rotated_vertex_t v;
        longint sx;
        longint sy;
        longint sz;
        longint s;
        longint c;
        sx = x;
        sy = y;
        sz = z;
        s = sine_q14(int'(ang));
        c = sine_q14(int'(ang) + int'(QUARTER_TURN));
        v.x = x;
        v.y = y;
        v.z = z;
        case (ax)
            AXIS_X:
            begin
                v.y = sat_q12(sy * c - sz * s);
                v.z = sat_q12(sy * s + sz * c);
            end
            AXIS_Y:
            begin
                v.x = sat_q12(sz * s + sx * c);
                v.z = sat_q12(sz * c - sx * s);
            end
            AXIS_Z:
            begin
                v.x = sat_q12(sx * c - sy * s);
                v.y = sat_q12(sx * s + sy * c);
            end
            default:
            begin
                // pass-through axis: vertex unchanged
            end
        endcase
        return v;
    endfunction

    task automatic check_coord(input string name, input logic signed [COORD_W-1:0] exp_v,
                               input logic signed [COORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        for (int k = 0; k <= 360; k++)
        begin
            sine_mag[k] = quarter_wave_q14(k);
        end
    end

    // watch config, accepted requests and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_qd = '0;
            axis_sel = AXIS_RESET;
            rotated_q.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                axis_sel = cfg_wdata;
            end
            if (vin.valid && vin.ready)
            begin
                if (vin.operation == OP_TICK)
                begin
                    // wrap from full turn back to zero
                    if (angle_qd >= FULL_TURN)
                    begin
                        angle_qd = '0;
                    end
                    else
                    begin
                        angle_qd = angle_qd + 1'b1;
                    end
                end
                else
                begin
                    rotated_q.push_back(rotate_vertex(axis_sel, angle_qd,
                                                      vin.vertex_x, vin.vertex_y,
                                                      vin.vertex_z));
                end
            end
            if (vout.valid && vout.ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got (%0d, %0d, %0d)",
                             $time, vout.rotated_x, vout.rotated_y, vout.rotated_z);
                    errors++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_coord("rotated_x", want.x, vout.rotated_x);
                    check_coord("rotated_y", want.y, vout.rotated_y);
                    check_coord("rotated_z", want.z, vout.rotated_z);
                end
            end
            fail_count <= errors;
            pending <= rotated_q.size();
        end
    end

endmodule

[tb/sv/tb_axis_vertex_rotator_core.sv]
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_axis_vertex_rotator_core;
    import avr_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int DRAIN       = 12;
    localparam int HOLD_LEN    = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 217;
    localparam int GAP_MAX     = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [AXIS_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                tx_gap_max = 0;
    int                rx_gap_max = 0;
    bit                pressure_on = 1'b0;
    bit                hold_done = 1'b0;
    int                cycles;

    avr_vertex_if vin ();
    avr_result_if vout ();

    axis_vertex_rotator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vertices  (vin),
        .results   (vout)
    );

    tb_avr_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .vin        (vin),
        .vout       (vout),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one request after a random gap, hold until accepted
    task automatic push_request(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0)
        begin
            vin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vin.valid     <= 1'b1;
        vin.operation <= op;
        vin.vertex_x  <= x;
        vin.vertex_y  <= y;
        vin.vertex_z  <= z;
        do @(posedge clk); while (!(vin.valid && vin.ready));
    endtask

    // stop offering, wait for all rotated vertices, then idle while the pipe clears
    task automatic settle();
        vin.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_axis(input logic [AXIS_W-1:0] ax);
        cfg_we    <= 1'b1;
        cfg_wdata <= ax;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // extremes often, small values sometimes, otherwise anything
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = '0;
            3: v = COORD_W'($signed($urandom_range(0, 32)) - 16);
            default: v = COORD_W'($urandom());
        endcase
        return v;
    endfunction

    // result side: random hold-offs, one long stall in the pressure phase
    initial
    begin
        int gap;
        int held;
        vout.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (pressure_on && !hold_done)
            begin
                vout.ready <= 1'b0;
                held = 0;
                while (held < HOLD_LEN)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1'b1;
            end
            else if (gap > 0)
            begin
                vout.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            vout.ready <= 1'b1;
            do @(posedge clk); while (!(vout.valid && vout.ready));
        end
    end

    // timeout
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase;
        int i;
        logic [OP_W-1:0] op;
        logic [AXIS_W-1:0] ax;
        vin.valid     <= 1'b0;
        vin.operation <= OP_TICK;
        vin.vertex_x  <= '0;
        vin.vertex_y  <= '0;
        vin.vertex_z  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= AXIS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset axis (X), angle zero, then two ticks
        push_request(OP_VERTEX, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        push_request(OP_VERTEX, 16'sh8000, 16'sh7FFF, 16'sh8000);
        push_request(OP_VERTEX, 16'sd1, -16'sd1, 16'sd1);
        push_request(OP_TICK, 16'sh8000, 16'sh7FFF, -16'sd1);
        push_request(OP_VERTEX, 16'sd4096, 16'sd4096, -16'sd4096);
        push_request(OP_TICK, -16'sd1, -16'sd1, -16'sd1);
        push_request(OP_VERTEX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        settle();
        write_axis(AXIS_Z);
        push_request(OP_VERTEX, 16'sh7FFF, 16'sh8000, 16'sd0);
        push_request(OP_VERTEX, -16'sd4096, 16'sd2048, 16'sd1);
        settle();
        write_axis(AXIS_Y);
        push_request(OP_VERTEX, 16'sh8000, 16'sd0, 16'sh7FFF);
        push_request(OP_VERTEX, 16'sd3, 16'sd5, -16'sd7);
        settle();
        write_axis(AXIS_PASS);
        push_request(OP_VERTEX, 16'sh8000, 16'sh7FFF, 16'sh8000);
        push_request(OP_TICK, 16'sd0, 16'sd0, 16'sd0);
        push_request(OP_VERTEX, -16'sd1, 16'sd0, 16'sd1);
        settle();

        // random phases: mostly ticks so the angle sweeps past a full turn
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: ax = AXIS_Z;
                1: ax = AXIS_X;
                2: ax = AXIS_PASS;
                3: ax = AXIS_Y;
                default: ax = AXIS_W'($urandom_range(0, 3));
            endcase
            write_axis(ax);
            pressure_on = (phase == 1);
            if (pressure_on || (phase % 3 == 0))
            begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            else
            begin
                tx_gap_max = GAP_MAX;
                rx_gap_max = GAP_MAX;
            end
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (pressure_on)
                begin
                    op = ($urandom_range(0, 1) != 0) ? OP_TICK : OP_VERTEX;
                end
                else
                begin
                    op = ($urandom_range(0, 11) != 0) ? OP_TICK : OP_VERTEX;
                end
                push_request(op, pick_coord(), pick_coord(), pick_coord());
            end
            settle();
            pressure_on = 1'b0;
        end

        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/avr_pkg.sv
rtl/avr_vertex_if.sv
rtl/avr_result_if.sv
rtl/avr_ram.sv
rtl/avr_angle_ctrl.sv
rtl/avr_rotate_pipe.sv
rtl/axis_vertex_rotator_core.sv
tb/sv/tb_avr_checker.sv
tb/sv/tb_axis_vertex_rotator_core.sv
